[hdl/gf2ie_pkg.sv]
// Shared types and constants for the GF(2) incremental elimination block.
// Depends on nothing; gf2ie_if, gf2ie_engine and the top level import it.
package gf2ie_pkg;

  // Field widths fixed by the channel definitions.
  localparam int MODE_W      = 2;
  localparam int ROW_W       = 64;
  localparam int IDX_OUT_W   = 6;
  localparam int CNT_W       = 7;
  localparam int VC_W        = 7;
  localparam int STATUS_W    = 2;
  localparam int FB_IW       = $clog2(ROW_W);
  localparam int UNKNOWNS_DEF = 64;

  localparam logic [VC_W-1:0] VC_RESET = 7'd64;

  // Item modes; the fourth code is unused and leaves the table alone.
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SOLVE  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE         = 2'd0,
    STAT_STORED       = 2'd1,
    STAT_REDUNDANT    = 2'd2,
    STAT_INCONSISTENT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_SOL_SCAN,
    ST_FINISH
  } eng_state_t;

  // One accepted input beat as handed to the engine.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ROW_W-1:0]  row_mask;
    logic              row_rhs;
    logic [ROW_W-1:0]  free_vals;
  } item_t;

  // One finished result as held by the engine.
  typedef struct packed {
    status_t              status;
    logic [IDX_OUT_W-1:0] pivot_index;
    logic [ROW_W-1:0]     assignment;
    logic [CNT_W-1:0]     rank;
  } result_t;

  // Top level to engine.
  typedef struct packed {
    logic start;
    logic take;
  } eng_ctl_t;

  // Engine to top level.
  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

endpackage

[hdl/gf2ie_if.sv]
// Valid/ready channel interfaces for the input items and the results.
// Depends on gf2ie_pkg for the field widths.
interface gf2ie_in_if;
  import gf2ie_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ROW_W-1:0]  row_mask;
  logic              row_rhs;
  logic [ROW_W-1:0]  free_vals;

  modport source (output valid, mode, row_mask, row_rhs, free_vals, input ready);
  modport sink   (input valid, mode, row_mask, row_rhs, free_vals, output ready);
endinterface

interface gf2ie_out_if;
  import gf2ie_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [IDX_OUT_W-1:0] pivot_index;
  logic [ROW_W-1:0]     assignment;
  logic [CNT_W-1:0]     rank;

  modport source (output valid, status, pivot_index, assignment, rank, input ready);
  modport sink   (input valid, status, pivot_index, assignment, rank, output ready);
endinterface

[hdl/gf2ie_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the pivot rows and their right-hand bits.
module gf2ie_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/gf2ie_engine.sv]
// Elimination engine: sequencer, shared XOR/parity unit and pivot table.
// Depends on gf2ie_pkg and gf2ie_ram.
module gf2ie_engine #(
  parameter int UNKNOWNS = gf2ie_pkg::UNKNOWNS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gf2ie_pkg::eng_ctl_t         ctl,
  input  gf2ie_pkg::item_t            item,
  input  logic [gf2ie_pkg::VC_W-1:0]  var_count,
  output gf2ie_pkg::eng_stat_t        stat,
  output gf2ie_pkg::result_t          res
);
  import gf2ie_pkg::*;

  localparam int IW = $clog2(UNKNOWNS);
  localparam int RW = UNKNOWNS + 1;

  eng_state_t          state_r, state_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [UNKNOWNS-1:0] row_r, row_nxt;
  logic                rhs_r, rhs_nxt;
  logic [UNKNOWNS-1:0] assign_r, assign_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [ROW_W-1:0]    fb_r, fb_nxt;
  logic [CNT_W-1:0]    limit_r, limit_nxt;
  logic [UNKNOWNS-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  status_t             status_r, status_nxt;
  logic [IW-1:0]       slot_r, slot_nxt;

  logic                ram_we;
  logic [RW-1:0]       ram_rdata;
  logic [UNKNOWNS-1:0] rd_row;
  logic                rd_rhs;

  // Pivot table: row bits with the right-hand bit on top.
  gf2ie_ram #(
    .WIDTH (RW),
    .DEPTH (UNKNOWNS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata ({rhs_r, row_r}),
    .raddr (idx_nxt),
    .rdata (ram_rdata)
  );

  assign rd_row = ram_rdata[UNKNOWNS-1:0];
  assign rd_rhs = ram_rdata[UNKNOWNS];

  // Control state, valid bits and the pivot count are reset; working registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
    idx_r    <= idx_nxt;
    row_r    <= row_nxt;
    rhs_r    <= rhs_nxt;
    assign_r <= assign_nxt;
    k_r      <= k_nxt;
    fb_r     <= fb_nxt;
    limit_r  <= limit_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
  end

  // Sequencer: one slot of the table is visited per cycle. The read for the
  // next slot is issued while the current one is evaluated.
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    row_nxt    = row_r;
    rhs_nxt    = rhs_r;
    assign_nxt = assign_r;
    k_nxt      = k_r;
    fb_nxt     = fb_r;
    limit_nxt  = limit_r;
    valid_nxt  = valid_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    ram_we     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (ctl.start) begin
          status_nxt = STAT_DONE;
          slot_nxt   = '0;
          assign_nxt = '0;
          row_nxt    = item.row_mask[UNKNOWNS-1:0];
          rhs_nxt    = item.row_rhs;
          fb_nxt     = item.free_vals;
          k_nxt      = '0;
          limit_nxt  = (var_count > CNT_W'(UNKNOWNS)) ? CNT_W'(UNKNOWNS) : var_count;
          unique case (item.mode)
            MODE_CLEAR: begin
              valid_nxt = '0;
              count_nxt = '0;
              state_nxt = ST_FINISH;
            end
            MODE_INSERT: begin
              idx_nxt   = IW'(UNKNOWNS - 1);
              state_nxt = ST_INS_SCAN;
            end
            MODE_SOLVE: begin
              idx_nxt   = '0;
              state_nxt = ST_SOL_SCAN;
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end

      // Walk downwards: the leading bit only ever moves down after a reduction.
      ST_INS_SCAN: begin
        if (row_r[idx_r] && !valid_r[idx_r]) begin
          ram_we           = 1'b1;
          valid_nxt[idx_r] = 1'b1;
          count_nxt        = count_r + 1'b1;
          status_nxt       = STAT_STORED;
          slot_nxt         = idx_r;
          state_nxt        = ST_FINISH;
        end else begin
          if (row_r[idx_r]) begin
            row_nxt = row_r ^ rd_row;
            rhs_nxt = rhs_r ^ rd_rhs;
          end
          if (idx_r == '0) begin
            status_nxt = rhs_nxt ? STAT_INCONSISTENT : STAT_REDUNDANT;
            state_nxt  = ST_FINISH;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end

      // Walk upwards: every bit above the current slot is still zero, so the
      // parity of the stored row against the partial assignment is exact.
      ST_SOL_SCAN: begin
        if (valid_r[idx_r]) begin
          assign_nxt[idx_r] = (^(rd_row & assign_r)) ^ rd_rhs;
        end else if (CNT_W'(idx_r) < limit_r) begin
          assign_nxt[idx_r] = fb_r[k_r[FB_IW-1:0]];
          k_nxt             = k_r + 1'b1;
        end
        if (idx_r == IW'(UNKNOWNS - 1)) begin
          state_nxt = ST_FINISH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_FINISH: begin
        if (ctl.take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign stat.idle = (state_r == ST_IDLE);
  assign stat.done = (state_r == ST_FINISH);

  assign res.status      = status_r;
  assign res.pivot_index = IDX_OUT_W'(slot_r);
  assign res.assignment  = ROW_W'(assign_r);
  assign res.rank        = count_r;

endmodule

[hdl/gf2_incremental_elimination_top.sv]
// Top level of the GF(2) incremental elimination block: channels, the
// variable count register and the result register around gf2ie_engine.
// Depends on gf2ie_pkg, gf2ie_if, gf2ie_ram and gf2ie_engine.
//
//   channel  direction  handshake       beat
//   in_ch    in         valid/ready     mode, row_mask, row_rhs, free_vals
//   out_ch   out        valid/ready     status, pivot_index, assignment, rank
//   cfg      in         cfg_we          cfg_wdata = variable_count
//
// A clear or unused-mode beat goes straight to the finish state, a solve visits every
// table slot and an insert walks down from the top slot until its row is stored or
// slot 0 is reached, one table slot per cycle through the single read port of the pivot RAM.
// The result enters the output register when the engine leaves its finish state.
// rst_n is synchronous; reset empties the pivot table at once. in_ch.ready is high
// only while the engine is idle; a result waiting on a stalled out_ch holds the engine.
module gf2_incremental_elimination_top #(
  parameter int UNKNOWNS = gf2ie_pkg::UNKNOWNS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [gf2ie_pkg::VC_W-1:0] cfg_wdata,
  gf2ie_in_if.sink                   in_ch,
  gf2ie_out_if.source                out_ch
);
  import gf2ie_pkg::*;

  logic [VC_W-1:0] var_count_r;
  eng_ctl_t        ctl;
  eng_stat_t       stat;
  item_t           item;
  result_t         res;
  logic            out_valid_r;
  result_t         out_res_r;

  // Variable count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_count_r <= VC_RESET;
    end else if (cfg_we) begin
      var_count_r <= cfg_wdata;
    end
  end

  // Input beat into the engine.
  assign item.mode      = in_ch.mode;
  assign item.row_mask  = in_ch.row_mask;
  assign item.row_rhs   = in_ch.row_rhs;
  assign item.free_vals = in_ch.free_vals;

  assign in_ch.ready = stat.idle;
  assign ctl.start   = in_ch.valid && stat.idle;
  assign ctl.take    = stat.done && (!out_valid_r || out_ch.ready);

  gf2ie_engine #(
    .UNKNOWNS (UNKNOWNS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .item      (item),
    .var_count (var_count_r),
    .stat      (stat),
    .res       (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (ctl.take) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.pivot_index = out_res_r.pivot_index;
  assign out_ch.assignment  = out_res_r.assignment;
  assign out_ch.rank        = out_res_r.rank;

  // An accepted beat leaves the engine busy in the cycle after it is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("engine ready straight after accepting a beat");

  // A stored row leaves at least one pivot in the table.
  a_stored_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == STAT_STORED |-> out_ch.rank != '0)
    else $error("stored row reported with an empty table");

  // The table never holds more pivots than unknowns.
  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.rank <= CNT_W'(UNKNOWNS))
    else $error("rank exceeds the number of unknowns");

  // Only a solve returns a non-zero assignment.
  a_assign_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != STAT_DONE |-> out_ch.assignment == '0)
    else $error("insert result carries an assignment");

endmodule
